/* sv/assert_macros.svh */
// Assertion macros used by the controller RTL file (shamd_ctrl.sv).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* sv/shamd_pkg.sv */
// Types, constants and round tables of the SHA-256 digest block.
package shamd_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COMPRESS,
      ST_FOLD,
      ST_PAD_MARK,
      ST_PAD_ZERO,
      ST_PAD_LEN,
      ST_OUTPUT
   } state_type;

   typedef enum logic [1:0] {
      SEL_INPUT,
      SEL_MARK,
      SEL_ZERO,
      SEL_LEN
   } byte_sel_type;

   typedef struct packed {
      logic         load_byte;
      byte_sel_type byte_sel;
      logic [2:0]   len_index;
      logic         count_bits;
      logic         round_en;
      logic [5:0]   round_index;
      logic         fold;
      logic         clear;
      logic [2:0]   out_index;
   } dp_cmd_type;

   typedef struct packed {
      logic [5:0] fill;
   } dp_status_type;

   localparam logic [7:0] PAD_MARK_BYTE = 8'h80;
   localparam logic [5:0] LEN_OFFSET    = 6'd56;
   localparam logic [5:0] LAST_POS      = 6'd63;

   function automatic logic [31:0] initial_hash(input logic [2:0] idx);
      logic [31:0] v;
      unique case (idx)
         3'd0: v = 32'h6a09e667;
         3'd1: v = 32'hbb67ae85;
         3'd2: v = 32'h3c6ef372;
         3'd3: v = 32'ha54ff53a;
         3'd4: v = 32'h510e527f;
         3'd5: v = 32'h9b05688c;
         3'd6: v = 32'h1f83d9ab;
         default: v = 32'h5be0cd19;
      endcase
      return v;
   endfunction

   function automatic logic [31:0] round_k(input logic [5:0] t);
      logic [31:0] k;
      unique case (t)
         6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
         6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
         6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
         6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
         6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
         6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
         6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
         6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
         6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
         6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
         6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
         6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
         6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
         6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
         6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
         6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
         6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
         6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
         6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
         6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
         6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
         6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
         6'd62: k = 32'hbef9a3f7;
         default: k = 32'hc67178f2;
      endcase
      return k;
   endfunction

endpackage

/* sv/shamd_datapath.sv */
// Datapath: byte packing, schedule window, round unit, hash and length registers.
module shamd_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  shamd_pkg::dp_cmd_type   cmd,
   input  logic [7:0]              in_byte,
   output shamd_pkg::dp_status_type status,
   output logic [31:0]             digest_word
);
   import shamd_pkg::*;

   logic [31:0] hash_ff [8];
   logic [31:0] hash_in [8];
   logic [31:0] vars_ff [8];
   logic [31:0] vars_in [8];
   logic [31:0] win_ff  [16];
   logic [31:0] win_in  [16];
   logic [23:0] acc_ff, acc_in;
   logic [5:0]  fill_ff, fill_in;
   logic [63:0] count_ff, count_in;

   logic [7:0]  put_byte;
   logic [31:0] sched_w, ssig0, ssig1;
   logic [31:0] big0, big1, choose, major, t1, t2;

   always_comb begin
      unique case (cmd.byte_sel)
         SEL_INPUT: put_byte = in_byte;
         SEL_MARK:  put_byte = PAD_MARK_BYTE;
         SEL_ZERO:  put_byte = 8'h00;
         default:   put_byte = count_ff[{~cmd.len_index, 3'b111} -: 8];
      endcase
   end

   // message schedule: first 16 rounds replay the loaded words
   assign ssig0 = {win_ff[1][6:0], win_ff[1][31:7]} ^ {win_ff[1][17:0], win_ff[1][31:18]}
                ^ (win_ff[1] >> 3);
   assign ssig1 = {win_ff[14][16:0], win_ff[14][31:17]}
                ^ {win_ff[14][18:0], win_ff[14][31:19]} ^ (win_ff[14] >> 10);
   assign sched_w = (cmd.round_index < 6'd16) ? win_ff[0]
                  : win_ff[0] + ssig0 + win_ff[9] + ssig1;

   assign big1 = {vars_ff[4][5:0], vars_ff[4][31:6]} ^ {vars_ff[4][10:0], vars_ff[4][31:11]}
               ^ {vars_ff[4][24:0], vars_ff[4][31:25]};
   assign choose = (vars_ff[4] & vars_ff[5]) ^ (~vars_ff[4] & vars_ff[6]);
   assign big0 = {vars_ff[0][1:0], vars_ff[0][31:2]} ^ {vars_ff[0][12:0], vars_ff[0][31:13]}
               ^ {vars_ff[0][21:0], vars_ff[0][31:22]};
   assign major = (vars_ff[0] & vars_ff[1]) ^ (vars_ff[0] & vars_ff[2])
                ^ (vars_ff[1] & vars_ff[2]);
   assign t1 = vars_ff[7] + big1 + choose + round_k(cmd.round_index) + sched_w;
   assign t2 = big0 + major;

   always_comb begin
      hash_in  = hash_ff;
      vars_in  = vars_ff;
      win_in   = win_ff;
      acc_in   = acc_ff;
      fill_in  = fill_ff;
      count_in = count_ff;
      if (cmd.load_byte) begin
         fill_in = fill_ff + 6'd1;
         if (fill_ff[1:0] == 2'd3) begin
            for (int i = 0; i < 15; i++) win_in[i] = win_ff[i+1];
            win_in[15] = {acc_ff, put_byte};
         end else begin
            acc_in = {acc_ff[15:0], put_byte};
         end
         if (fill_ff == LAST_POS) vars_in = hash_ff;
      end
      if (cmd.count_bits) count_in = count_ff + 64'd8;
      if (cmd.round_en) begin
         for (int i = 0; i < 15; i++) win_in[i] = win_ff[i+1];
         win_in[15] = sched_w;
         vars_in[7] = vars_ff[6];
         vars_in[6] = vars_ff[5];
         vars_in[5] = vars_ff[4];
         vars_in[4] = vars_ff[3] + t1;
         vars_in[3] = vars_ff[2];
         vars_in[2] = vars_ff[1];
         vars_in[1] = vars_ff[0];
         vars_in[0] = t1 + t2;
      end
      if (cmd.fold) begin
         for (int i = 0; i < 8; i++) hash_in[i] = hash_ff[i] + vars_ff[i];
      end
      if (cmd.clear) begin
         for (int i = 0; i < 8; i++) hash_in[i] = initial_hash(3'(i));
         fill_in  = '0;
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) hash_ff[i] <= initial_hash(3'(i));
         fill_ff  <= '0;
         count_ff <= '0;
      end else begin
         hash_ff  <= hash_in;
         fill_ff  <= fill_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      vars_ff <= vars_in;
      win_ff  <= win_in;
      acc_ff  <= acc_in;
   end

   assign status.fill = fill_ff;
   assign digest_word = hash_ff[cmd.out_index];

endmodule

/* sv/shamd_ctrl.sv */
// Controller: input handshake, padding sequence, round count and digest readout.
`include "assert_macros.svh"
module shamd_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_carries_byte,
   input  logic                     req_is_last,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  shamd_pkg::dp_status_type status,
   output shamd_pkg::dp_cmd_type    cmd
);
   import shamd_pkg::*;

   state_type   state_ff, state_in;
   state_type   ret_ff, ret_in;
   logic [5:0]  round_ff, round_in;
   logic [2:0]  len_ff, len_in;
   logic [2:0]  out_ff, out_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ret_ff   <= ST_IDLE;
         round_ff <= '0;
         len_ff   <= '0;
         out_ff   <= '0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         round_ff <= round_in;
         len_ff   <= len_in;
         out_ff   <= out_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      ret_in    = ret_ff;
      round_in  = round_ff;
      len_in    = len_ff;
      out_in    = out_ff;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      cmd             = '0;
      cmd.byte_sel    = SEL_INPUT;
      cmd.len_index   = len_ff;
      cmd.round_index = round_ff;
      cmd.out_index   = out_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_byte  = req_carries_byte;
               cmd.count_bits = req_carries_byte;
               if (req_carries_byte && status.fill == LAST_POS) begin
                  state_in = ST_COMPRESS;
                  ret_in   = req_is_last ? ST_PAD_MARK : ST_IDLE;
               end else if (req_is_last) begin
                  state_in = ST_PAD_MARK;
               end
            end
         end
         ST_COMPRESS: begin
            cmd.round_en = 1'b1;
            round_in = round_ff + 6'd1;
            if (round_ff == LAST_POS) state_in = ST_FOLD;
         end
         ST_FOLD: begin
            cmd.fold = 1'b1;
            state_in = ret_ff;
         end
         ST_PAD_MARK: begin
            cmd.load_byte = 1'b1;
            cmd.byte_sel  = SEL_MARK;
            if (status.fill == LAST_POS) begin
               state_in = ST_COMPRESS;
               ret_in   = ST_PAD_ZERO;
            end else begin
               state_in = ST_PAD_ZERO;
            end
         end
         ST_PAD_ZERO: begin
            if (status.fill == LEN_OFFSET) begin
               state_in = ST_PAD_LEN;
            end else begin
               cmd.load_byte = 1'b1;
               cmd.byte_sel  = SEL_ZERO;
               if (status.fill == LAST_POS) begin
                  state_in = ST_COMPRESS;
                  ret_in   = ST_PAD_ZERO;
               end
            end
         end
         ST_PAD_LEN: begin
            cmd.load_byte = 1'b1;
            cmd.byte_sel  = SEL_LEN;
            len_in = len_ff + 3'd1;
            if (len_ff == 3'd7) begin
               state_in = ST_COMPRESS;
               ret_in   = ST_OUTPUT;
            end
         end
         ST_OUTPUT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               out_in = out_ff + 3'd1;
               if (out_ff == 3'd7) begin
                  cmd.clear = 1'b1;
                  state_in  = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   `ASSERT_IMPL(a_no_overlap, clock, reset, rsp_valid, req_stall)
   `ASSERT_NEXT(a_rounds_to_fold, clock, reset,
                state_ff == ST_COMPRESS && round_ff == LAST_POS, state_ff == ST_FOLD)
   `ASSERT_IMPL(a_block_done_on_output, clock, reset, state_ff == ST_OUTPUT, status.fill == 6'd0)
   `ASSERT_NEXT(a_len_ends_block, clock, reset,
                state_ff == ST_PAD_LEN && len_ff == 3'd7, status.fill == 6'd0)
   `ASSERT_NEXT(a_clear_after_digest, clock, reset, cmd.clear, state_ff == ST_IDLE && out_ff == 3'd0)

endmodule

/* sv/sha256_message_digest.sv */
// SHA-256 digest core: one message byte per word, eight digest words per message.
// Throughput: one byte per cycle while a block fills; a full block then stalls input
// while the single round unit runs its 64 rounds and the hash update is made.
// Output: after the last word is taken, the padding (one or two padded blocks) is compressed
// before rsp_valid rises; digest words then go out one per unstalled cycle.
// Reset (synchronous, active high) loads the initial hash; re-initializes after each digest.
module sha256_message_digest (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_carries_byte,
   input  logic        req_is_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);
   import shamd_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   shamd_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_carries_byte (req_carries_byte),
      .req_is_last      (req_is_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .status           (status),
      .cmd              (cmd)
   );

   shamd_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .in_byte     (req_data_byte),
      .status      (status),
      .digest_word (rsp_digest_word)
   );

   assign rsp_word_index = cmd.out_index;
   assign rsp_last_word  = (cmd.out_index == 3'd7);

endmodule
